@@ rtl/core/sha256_pkg.sv @@
// ----------------------------------------------------------------------------
// sha256_pkg
// round constants, initial hash values and the sha-256 round functions
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  typedef logic [31:0] word_t;

  function automatic word_t ror(input word_t x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t small_s0(input word_t x);
    small_s0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_s1(input word_t x);
    small_s1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t big_s0(input word_t x);
    big_s0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t big_s1(input word_t x);
    big_s1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage

@@ rtl/core/sha256_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// byte-serial sha-256 with padding and eight-word digest output
// ----------------------------------------------------------------------------
// A byte request is taken only while idle. The 64th byte of a block also
// starts the compression, and input stays blocked while it runs: 64 rounds
// through one shared round unit, one a cycle, then a fold of the result into
// the chain; no new byte is taken before that fold. A finishing request
// first writes the pad bytes, one a cycle, from the 0x80 position up to
// position 63, then runs a compression. A second pad block and compression
// follow when the 0x80 lands at position 56 or later. The eight digest words
// then go out, word 0 first, one per accepted result. When the finish rides
// on the 64th byte, that block is compressed first. The message schedule is
// a 16-word sliding window, loaded from the buffer during the first 16 rounds.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [0] has_byte, [1] end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // last_word
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_ROUND, S_FOLD, S_EMIT
  } state_t;

  state_t             state_r;
  logic [31:0]        h_r [8];
  logic [31:0]        v_r [8];
  logic [31:0]        w_r [16];
  logic [31:0]        blk_r [16];  // block buffer, big-endian bytes per word
  logic [5:0]         pend_r;
  logic [63:0]        bits_r;
  logic [5:0]         rnd_r;
  logic               fin_r;       // finish pending after this data block
  logic               pad_mode_r;  // compression in flight is a pad block
  logic               len_blk_r;   // current pad block carries the length
  logic               mark_r;      // next pad byte is the 0x80 marker
  logic [5:0]         pad_r;
  logic [2:0]         oidx_r;

  // message word for this round
  logic [31:0] w_cur, t1, t2;
  always_comb begin
    if (rnd_r < 6'd16) begin
      w_cur = blk_r[rnd_r[3:0]];
    end else begin
      w_cur = sha256_pkg::small_s1(w_r[14]) + w_r[9]
            + sha256_pkg::small_s0(w_r[1]) + w_r[0];
    end
    t1 = v_r[7] + sha256_pkg::big_s1(v_r[4])
       + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
       + sha256_pkg::ROUND_K[rnd_r] + w_cur;
    t2 = sha256_pkg::big_s0(v_r[0])
       + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  // pad byte at position pad_r
  logic [7:0] pad_byte;
  always_comb begin
    if (mark_r) begin
      pad_byte = sha256_pkg::PAD_BYTE;
    end else if (len_blk_r && pad_r >= sha256_pkg::LEN_POS) begin
      pad_byte = bits_r[{~pad_r[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_EMIT);
  assign out_tdata  = h_r[oidx_r];
  assign out_tuser  = oidx_r;
  assign out_tlast  = (oidx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pend_r     <= '0;
      bits_r     <= '0;
      rnd_r      <= '0;
      fin_r      <= 1'b0;
      pad_mode_r <= 1'b0;
      len_blk_r  <= 1'b0;
      mark_r     <= 1'b0;
      pad_r      <= '0;
      oidx_r     <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha256_pkg::INIT_H[i];
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            if (in_tuser[0]) begin
              blk_r[pend_r[5:2]][{~pend_r[1:0], 3'b000} +: 8] <= in_tdata;
              pend_r <= pend_r + 6'd1;
              bits_r <= bits_r + 64'd8;
            end
            if (in_tuser[0] && pend_r == 6'd63) begin
              fin_r <= in_tuser[1];
              rnd_r <= '0;
              for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
              state_r <= S_ROUND;
            end else if (in_tuser[1]) begin
              // marker goes right after the last message byte
              pad_r      <= in_tuser[0] ? pend_r + 6'd1 : pend_r;
              len_blk_r  <= in_tuser[0] ? (pend_r < sha256_pkg::LEN_POS - 6'd1)
                                        : (pend_r < sha256_pkg::LEN_POS);
              mark_r     <= 1'b1;
              pad_mode_r <= 1'b1;
              state_r    <= S_PAD;
            end
          end
        end
        S_PAD: begin
          blk_r[pad_r[5:2]][{~pad_r[1:0], 3'b000} +: 8] <= pad_byte;
          mark_r <= 1'b0;
          pad_r  <= pad_r + 6'd1;
          if (pad_r == 6'd63) begin
            rnd_r <= '0;
            for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
            state_r <= S_ROUND;
          end
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
          w_r[15] <= w_cur;
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          rnd_r  <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) state_r <= S_FOLD;
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          if (pad_mode_r && len_blk_r) begin
            oidx_r  <= '0;
            state_r <= S_EMIT;
          end else if (pad_mode_r) begin
            // second pad block: zeros then the length
            pad_r     <= '0;
            mark_r    <= 1'b0;
            len_blk_r <= 1'b1;
            state_r   <= S_PAD;
          end else if (fin_r) begin
            // finish right after a full data block
            fin_r      <= 1'b0;
            pad_r      <= '0;
            mark_r     <= 1'b1;
            len_blk_r  <= 1'b1;
            pad_mode_r <= 1'b1;
            state_r    <= S_PAD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_tready) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) h_r[i] <= sha256_pkg::INIT_H[i];
              pend_r     <= '0;
              bits_r     <= '0;
              pad_mode_r <= 1'b0;
              state_r    <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
